@@ src/assert_macros.svh @@
// Assertion macros for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CBM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cbm assertion failed");
`define CBM_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("cbm forbidden condition");
`else
`define CBM_ASSERT(lbl, clk, rst, prop)
`define CBM_NEVER(lbl, clk, rst, cond)
`endif
`endif

@@ src/cbm_pkg.sv @@
// Types, constants and codes of the cartridge bank mapper
package cbm_pkg;

   localparam int unsigned ROM_BANK_BYTES = 16384;
   localparam int unsigned RAM_BANK_BYTES = 8192;
   localparam int unsigned ROM_OFS_W      = $clog2(ROM_BANK_BYTES);
   localparam int unsigned RAM_OFS_W      = $clog2(RAM_BANK_BYTES);

   localparam int unsigned ADDR_W      = 16;
   localparam int unsigned DATA_W      = 8;
   localparam int unsigned PHYS_W      = 21;
   localparam int unsigned ROM_BANK_W  = 7;
   localparam int unsigned RAM_BANK_W  = 2;
   localparam int unsigned ROM_CNT_W   = 8;
   localparam int unsigned RAM_CNT_W   = 3;
   localparam int unsigned CSR_ADDR_W  = 1;
   localparam int unsigned CSR_DATA_W  = 8;

   localparam int unsigned DIV_STEPS   = DATA_W;
   localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam logic [ROM_CNT_W-1:0]  ROM_CNT_RESET = 8'd2;
   localparam logic [RAM_CNT_W-1:0]  RAM_CNT_RESET = 3'd1;
   localparam logic [ROM_BANK_W-1:0] ROM_SEL_RESET = 7'd1;

   localparam logic [3:0] RAM_EN_KEY = 4'hA;
   localparam logic [2:0] RAM_REGION = 3'b101;

   typedef enum logic [1:0] {
      TGT_NONE = 2'd0,
      TGT_ROM  = 2'd1,
      TGT_RAM  = 2'd2
   } target_type;

   typedef enum logic [1:0] {
      CTL_RAM_EN  = 2'd0,
      CTL_ROM_LO  = 2'd1,
      CTL_BANK_HI = 2'd2,
      CTL_MODE    = 2'd3
   } ctl_range_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ROM_BANK_COUNT = 1'd0,
      CSR_RAM_BANK_COUNT = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic load;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic div_needed;
      logic div_last;
   } sts_type;

endpackage

@@ src/cbm_if.sv @@
// Request and response channel interfaces
interface cbm_req_if;
   logic                        valid;
   logic                        ready;
   logic                        action;
   logic [cbm_pkg::ADDR_W-1:0]  bus_address;
   logic [cbm_pkg::DATA_W-1:0]  write_data;

   modport source (output valid, action, bus_address, write_data, input ready);
   modport sink   (input valid, action, bus_address, write_data, output ready);
endinterface

interface cbm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  target;
   logic [cbm_pkg::PHYS_W-1:0]  physical_address;
   logic                        memory_write;
   logic [cbm_pkg::DATA_W-1:0]  memory_data;

   modport source (output valid, target, physical_address, memory_write, memory_data,
                   input ready);
   modport sink   (input valid, target, physical_address, memory_write, memory_data,
                   output ready);
endinterface

@@ src/cbm_ctrl.sv @@
// Controller state machine: accept, divide, respond
module cbm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cbm_pkg::cmd_type cmd,
   input  cbm_pkg::sts_type sts
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sts.div_needed ? ST_DIV : ST_RESP;
            end
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/cbm_datapath.sv @@
// Datapath: mapper state, config registers, remainder unit, result register
module cbm_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [cbm_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [cbm_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             action,
   input  logic [cbm_pkg::ADDR_W-1:0]       bus_address,
   input  logic [cbm_pkg::DATA_W-1:0]       write_data,
   input  cbm_pkg::cmd_type                 cmd,
   output cbm_pkg::sts_type                 sts,
   output logic [1:0]                       target,
   output logic [cbm_pkg::PHYS_W-1:0]       physical_address,
   output logic                             memory_write,
   output logic [cbm_pkg::DATA_W-1:0]       memory_data
);

   localparam int unsigned DW = cbm_pkg::DATA_W;

   logic [cbm_pkg::ROM_CNT_W-1:0]  rom_cnt_ff;
   logic [cbm_pkg::RAM_CNT_W-1:0]  ram_cnt_ff;
   logic                           ram_en_ff, ram_en_in;
   logic                           mode_ff, mode_in;
   logic [cbm_pkg::ROM_BANK_W-1:0] rom_sel_ff, rom_sel_in;
   logic [cbm_pkg::RAM_BANK_W-1:0] ram_sel_ff, ram_sel_in;

   logic [DW-1:0]                  quo_ff, quo_in;
   logic [DW-1:0]                  rem_ff, rem_in;
   logic [DW-1:0]                  div_ff, div_in;
   logic [cbm_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                           is_ram_ff, is_ram_in;

   cbm_pkg::target_type            tgt_ff, tgt_in;
   logic [cbm_pkg::PHYS_W-1:0]     phys_ff, phys_in;
   logic                           mwr_ff, mwr_in;
   logic [DW-1:0]                  mdata_ff, mdata_in;

   logic                           in_ram_rgn;
   logic                           is_ctl;
   cbm_pkg::ctl_range_type         ctl_rng;
   logic [cbm_pkg::RAM_BANK_W-1:0] ram_bank;
   logic [DW:0]                    trial;
   logic                           fits;
   logic [DW-1:0]                  rem_step;
   logic [cbm_pkg::ROM_BANK_W-1:0] fixed_bank;

   assign in_ram_rgn = (bus_address[15:13] == cbm_pkg::RAM_REGION);
   assign is_ctl     = !in_ram_rgn && action && !bus_address[15];
   assign ctl_rng    = cbm_pkg::ctl_range_type'(bus_address[14:13]);
   assign ram_bank   = mode_ff ? '0 : ram_sel_ff;

   assign sts.div_needed = is_ctl && (ctl_rng == cbm_pkg::CTL_ROM_LO ||
                                      ctl_rng == cbm_pkg::CTL_BANK_HI);
   assign sts.div_last   = (cnt_ff == cbm_pkg::DIV_CNT_W'(cbm_pkg::DIV_STEPS - 1));

   assign trial    = {rem_ff, quo_ff[DW-1]};
   assign fits     = (trial >= {1'b0, div_ff});
   assign rem_step = fits ? DW'(trial - {1'b0, div_ff}) : trial[DW-1:0];

   always_comb begin
      fixed_bank = rem_step[cbm_pkg::ROM_BANK_W-1:0];
      if (fixed_bank[4:0] == 5'd0) begin
         fixed_bank = fixed_bank + 1'b1;
      end
   end

   always_comb begin
      ram_en_in  = ram_en_ff;
      mode_in    = mode_ff;
      rom_sel_in = rom_sel_ff;
      ram_sel_in = ram_sel_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      div_in     = div_ff;
      cnt_in     = cnt_ff;
      is_ram_in  = is_ram_ff;
      tgt_in     = tgt_ff;
      phys_in    = phys_ff;
      mwr_in     = mwr_ff;
      mdata_in   = mdata_ff;

      if (cmd.step) begin
         rem_in = rem_step;
         quo_in = {quo_ff[DW-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
      end

      if (cmd.step && sts.div_last) begin
         if (is_ram_ff) begin
            ram_sel_in = rem_step[cbm_pkg::RAM_BANK_W-1:0];
         end else begin
            rom_sel_in = fixed_bank;
         end
      end

      if (cmd.load) begin
         tgt_in   = cbm_pkg::TGT_NONE;
         phys_in  = '0;
         mwr_in   = 1'b0;
         mdata_in = '0;
         rem_in   = '0;
         cnt_in   = '0;
         if (in_ram_rgn) begin
            if (ram_en_ff) begin
               tgt_in  = cbm_pkg::TGT_RAM;
               phys_in = cbm_pkg::PHYS_W'({ram_bank, bus_address[cbm_pkg::RAM_OFS_W-1:0]});
               if (action) begin
                  mwr_in   = 1'b1;
                  mdata_in = write_data;
               end
            end
         end else if (!action) begin
            if (!bus_address[15]) begin
               tgt_in = cbm_pkg::TGT_ROM;
               if (!bus_address[14]) begin
                  phys_in = cbm_pkg::PHYS_W'(bus_address);
               end else begin
                  phys_in = {rom_sel_ff, bus_address[cbm_pkg::ROM_OFS_W-1:0]};
               end
            end
         end else if (is_ctl) begin
            unique case (ctl_rng)
               cbm_pkg::CTL_RAM_EN: begin
                  ram_en_in = (write_data[3:0] == cbm_pkg::RAM_EN_KEY);
               end
               cbm_pkg::CTL_ROM_LO: begin
                  is_ram_in = 1'b0;
                  quo_in    = DW'({rom_sel_ff[6:5], write_data[4:0]});
                  div_in    = rom_cnt_ff;
               end
               cbm_pkg::CTL_BANK_HI: begin
                  is_ram_in = !mode_ff;
                  if (mode_ff) begin
                     quo_in = DW'({write_data[1:0], rom_sel_ff[4:0]});
                     div_in = rom_cnt_ff;
                  end else begin
                     quo_in = write_data;
                     div_in = DW'(ram_cnt_ff);
                  end
               end
               cbm_pkg::CTL_MODE: begin
                  mode_in = write_data[0];
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_cnt_ff <= cbm_pkg::ROM_CNT_RESET;
         ram_cnt_ff <= cbm_pkg::RAM_CNT_RESET;
         ram_en_ff  <= 1'b0;
         mode_ff    <= 1'b0;
         rom_sel_ff <= cbm_pkg::ROM_SEL_RESET;
         ram_sel_ff <= '0;
      end else begin
         ram_en_ff  <= ram_en_in;
         mode_ff    <= mode_in;
         rom_sel_ff <= rom_sel_in;
         ram_sel_ff <= ram_sel_in;
         if (csr_we) begin
            unique case (cbm_pkg::csr_index_type'(csr_addr))
               cbm_pkg::CSR_ROM_BANK_COUNT: rom_cnt_ff <= csr_wdata[cbm_pkg::ROM_CNT_W-1:0];
               cbm_pkg::CSR_RAM_BANK_COUNT: ram_cnt_ff <= csr_wdata[cbm_pkg::RAM_CNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      div_ff    <= div_in;
      cnt_ff    <= cnt_in;
      is_ram_ff <= is_ram_in;
      tgt_ff    <= tgt_in;
      phys_ff   <= phys_in;
      mwr_ff    <= mwr_in;
      mdata_ff  <= mdata_in;
   end

   assign target           = tgt_ff;
   assign physical_address = phys_ff;
   assign memory_write     = mwr_ff;
   assign memory_data      = mdata_ff;

endmodule

@@ src/cartridge_bank_mapper.sv @@
// Cartridge bank mapper: maps CPU bus accesses onto banked ROM and external RAM.
// req_bus carries one bus access (action, bus_address, write_data); rsp_bus returns
// one result per access: target, physical_address, memory_write, memory_data.
// A transfer happens on a clock edge with valid and ready both high.
// Reads, RAM accesses and writes outside the ROM bank and upper bank ranges: the
// result is valid in the cycle after the request transfer.
// Writes to the ROM bank and upper bank ranges run the new bank value through a
// bit-serial remainder unit, one dividend bit per cycle: the result is valid in the
// response state that follows the last division step.
// One access is in flight at a time; req_bus.ready is low until the result of the
// current access has been transferred, so a stalled receiver holds off requests.
// The csr port sets the ROM and RAM bank counts; write it only while idle.
// Synchronous reset: RAM disabled, mode 0, ROM bank 1, RAM bank 0, bank counts
// 2 and 1, no result pending.
module cartridge_bank_mapper (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [cbm_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [cbm_pkg::CSR_DATA_W-1:0] csr_wdata,
   cbm_req_if.sink                        req_bus,
   cbm_rsp_if.source                      rsp_bus
);

`include "assert_macros.svh"

   cbm_pkg::cmd_type cmd;
   cbm_pkg::sts_type sts;

   logic req_read_xfer;
   logic rsp_none;
   logic rsp_blank;
   logic rsp_write;
   logic rsp_ram;

   cbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   cbm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata),
      .action           (req_bus.action),
      .bus_address      (req_bus.bus_address),
      .write_data       (req_bus.write_data),
      .cmd              (cmd),
      .sts              (sts),
      .target           (rsp_bus.target),
      .physical_address (rsp_bus.physical_address),
      .memory_write     (rsp_bus.memory_write),
      .memory_data      (rsp_bus.memory_data)
   );

   assign req_read_xfer = req_bus.valid && req_bus.ready && !req_bus.action;
   assign rsp_none      = rsp_bus.valid && (rsp_bus.target == cbm_pkg::TGT_NONE);
   assign rsp_blank     = (rsp_bus.physical_address == '0) && !rsp_bus.memory_write;
   assign rsp_write     = rsp_bus.valid && rsp_bus.memory_write;
   assign rsp_ram       = (rsp_bus.target == cbm_pkg::TGT_RAM);

   `CBM_NEVER(a_one_in_flight, clock, reset, req_bus.ready && rsp_bus.valid)
   `CBM_ASSERT(a_read_one_cycle, clock, reset, req_read_xfer |=> rsp_bus.valid)
   `CBM_ASSERT(a_none_is_zero, clock, reset, rsp_none |-> rsp_blank)
   `CBM_ASSERT(a_write_hits_ram, clock, reset, rsp_write |-> rsp_ram)

endmodule

@@ bench/cartridge_bank_mapper_tb.sv @@
// Self-checking testbench for the cartridge bank mapper: directed and random bus accesses
typedef struct packed {
   cbm_pkg::target_type             target;
   logic [cbm_pkg::PHYS_W-1:0]      phys;
   logic                            mem_wr;
   logic [cbm_pkg::DATA_W-1:0]      mem_data;
} bus_mapping_type;

class mapper_scoreboard;
   logic [cbm_pkg::ROM_CNT_W-1:0]   rom_count;
   logic [cbm_pkg::RAM_CNT_W-1:0]   ram_count;
   logic                            ram_on;
   logic                            mode;
   logic [cbm_pkg::ROM_BANK_W-1:0]  rom_bank;
   logic [cbm_pkg::RAM_BANK_W-1:0]  ram_bank;
   bus_mapping_type                 pending_mappings[$];
   int                              errors;

   function new();
      rom_count = cbm_pkg::ROM_CNT_RESET;
      ram_count = cbm_pkg::RAM_CNT_RESET;
      ram_on    = 1'b0;
      mode      = 1'b0;
      rom_bank  = cbm_pkg::ROM_SEL_RESET;
      ram_bank  = '0;
      errors    = 0;
   endfunction

   task report(string what);
      errors++;
      $display("mismatch: %s", what);
   endtask

   function int pending();
      return pending_mappings.size();
   endfunction

   function void set_register(cbm_pkg::csr_index_type idx, logic [7:0] value);
      case (idx)
         cbm_pkg::CSR_ROM_BANK_COUNT: rom_count = value;
         cbm_pkg::CSR_RAM_BANK_COUNT: ram_count = value[2:0];
         default: ;
      endcase
   endfunction

   // modulo bank count, then banks 00/20/40/60 step up by one
   function logic [6:0] fold_rom_bank(logic [6:0] bank);
      logic [7:0] b;
      b = {1'b0, bank};
      if (rom_count != 0) b = b % rom_count;
      if (b[4:0] == 5'd0) b = b + 8'd1;
      return b[6:0];
   endfunction

   function bus_mapping_type predict_mapping(logic is_write, logic [15:0] addr,
                                             logic [7:0] data);
      bus_mapping_type r;
      logic [7:0]      b;
      r = '{cbm_pkg::TGT_NONE, '0, 1'b0, '0};
      if (addr[15:13] == cbm_pkg::RAM_REGION) begin
         if (ram_on) begin
            r.target = cbm_pkg::TGT_RAM;
            r.phys   = {6'd0, (mode ? 2'd0 : ram_bank), addr[12:0]};
            if (is_write) begin
               r.mem_wr   = 1'b1;
               r.mem_data = data;
            end
         end
      end else if (!is_write) begin
         if (!addr[15]) begin
            r.target = cbm_pkg::TGT_ROM;
            r.phys   = addr[14] ? {rom_bank, addr[13:0]} : {5'd0, addr};
         end
      end else if (!addr[15]) begin
         case (cbm_pkg::ctl_range_type'(addr[14:13]))
            cbm_pkg::CTL_RAM_EN:  ram_on = (data[3:0] == cbm_pkg::RAM_EN_KEY);
            cbm_pkg::CTL_ROM_LO:  rom_bank = fold_rom_bank({rom_bank[6:5], data[4:0]});
            cbm_pkg::CTL_BANK_HI: begin
               if (mode) begin
                  rom_bank = fold_rom_bank({data[1:0], rom_bank[4:0]});
               end else begin
                  b = data;
                  if (ram_count != 0) b = b % {5'd0, ram_count};
                  ram_bank = b[1:0];
               end
            end
            cbm_pkg::CTL_MODE:    mode = data[0];
            default: ;
         endcase
      end
      return r;
   endfunction

   function void note_access(logic is_write, logic [15:0] addr, logic [7:0] data);
      pending_mappings.push_back(predict_mapping(is_write, addr, data));
   endfunction

   task check_mapping(logic [1:0] tgt, logic [20:0] phys, logic wr, logic [7:0] data);
      bus_mapping_type e;
      if (pending_mappings.size() == 0) begin
         report($sformatf("result with nothing expected: target %0d addr %h", tgt, phys));
      end else begin
         e = pending_mappings.pop_front();
         if (tgt !== e.target)
            report($sformatf("target %0d, expected %0d", tgt, e.target));
         if (phys !== e.phys)
            report($sformatf("physical_address %h, expected %h", phys, e.phys));
         if (wr !== e.mem_wr)
            report($sformatf("memory_write %b, expected %b", wr, e.mem_wr));
         if (data !== e.mem_data)
            report($sformatf("memory_data %h, expected %h", data, e.mem_data));
      end
   endtask
endclass

module cartridge_bank_mapper_tb;

   localparam logic ACT_READ    = 1'b0;
   localparam logic ACT_WRITE   = 1'b1;
   localparam int   CYCLE_LIMIT = 400000;
   localparam int   NUM_PHASES  = 10;

   logic                            clock;
   logic                            reset;
   logic                            csr_we;
   logic [cbm_pkg::CSR_ADDR_W-1:0]  csr_addr;
   logic [cbm_pkg::CSR_DATA_W-1:0]  csr_wdata;

   cbm_req_if req_bus();
   cbm_rsp_if rsp_bus();

   mapper_scoreboard sb;
   bit               quiet;
   int               stall_left;
   int               cycle_count = 0;

   cartridge_bank_mapper u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // result side: check each transfer, stall in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_mapping(rsp_bus.target, rsp_bus.physical_address,
                             rsp_bus.memory_write, rsp_bus.memory_data);
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task write_counts(logic [7:0] rom_cnt, logic [2:0] ram_cnt);
      csr_we    <= 1'b1;
      csr_addr  <= cbm_pkg::CSR_ROM_BANK_COUNT;
      csr_wdata <= rom_cnt;
      @(posedge clock);
      csr_addr  <= cbm_pkg::CSR_RAM_BANK_COUNT;
      csr_wdata <= {5'd0, ram_cnt};
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_register(cbm_pkg::CSR_ROM_BANK_COUNT, rom_cnt);
      sb.set_register(cbm_pkg::CSR_RAM_BANK_COUNT, {5'd0, ram_cnt});
   endtask

   task send_access(logic is_write, logic [15:0] addr, logic [7:0] data);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.action      <= is_write;
      req_bus.bus_address <= addr;
      req_bus.write_data  <= data;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_access(is_write, addr, data);
   endtask

   task send_random(int count);
      int          pick;
      logic        is_write;
      logic [15:0] addr;
      logic [7:0]  data;
      repeat (count) begin
         pick     = $urandom_range(0, 99);
         data     = 8'($urandom_range(0, 255));
         is_write = 1'($urandom_range(0, 1));
         if (pick < 30) begin
            is_write = ACT_READ;
            addr     = 16'($urandom_range(0, 16'h7FFF));
         end else if (pick < 55) begin
            addr = 16'hA000 + 16'($urandom_range(0, 16'h1FFF));
         end else if (pick < 85) begin
            is_write = ACT_WRITE;
            addr     = 16'($urandom_range(0, 16'h7FFF));
            if (addr < 16'h2000 && $urandom_range(0, 1) == 1)
               data[3:0] = cbm_pkg::RAM_EN_KEY;
         end else begin
            addr = 16'($urandom_range(0, 16'hFFFF));
         end
         send_access(is_write, addr, data);
      end
   endtask

   task send_directed();
      send_access(ACT_WRITE, 16'h0000, 8'h0A);
      send_access(ACT_READ,  16'hA000, 8'h00);
      send_access(ACT_WRITE, 16'hBFFF, 8'hFF);
      send_access(ACT_WRITE, 16'h1FFF, 8'h1B);
      send_access(ACT_READ,  16'hBFFF, 8'h00);
      send_access(ACT_WRITE, 16'h0000, 8'hFA);
      send_access(ACT_WRITE, 16'h6000, 8'h00);
      send_access(ACT_WRITE, 16'h4000, 8'hFF);
      send_access(ACT_READ,  16'hA123, 8'h00);
      send_access(ACT_WRITE, 16'h2000, 8'h00);
      send_access(ACT_READ,  16'h4000, 8'h00);
      send_access(ACT_WRITE, 16'h7FFF, 8'h01);
      send_access(ACT_WRITE, 16'h5FFF, 8'h03);
      send_access(ACT_READ,  16'h7FFF, 8'h00);
      send_access(ACT_WRITE, 16'h3FFF, 8'h1F);
      send_access(ACT_READ,  16'h4000, 8'h00);
      send_access(ACT_WRITE, 16'hB000, 8'h5A);
      send_access(ACT_WRITE, 16'h4000, 8'h01);
      send_access(ACT_WRITE, 16'h2000, 8'hE0);
      send_access(ACT_READ,  16'h5555, 8'h00);
      send_access(ACT_READ,  16'h0000, 8'h00);
      send_access(ACT_READ,  16'h3FFF, 8'h00);
      send_access(ACT_READ,  16'h8000, 8'h00);
      send_access(ACT_WRITE, 16'h9FFF, 8'h77);
      send_access(ACT_WRITE, 16'hFFFF, 8'h5A);
      send_access(ACT_WRITE, 16'h6000, 8'hFE);
   endtask

   initial begin
      logic [7:0] rom_counts [NUM_PHASES];
      logic [2:0] ram_counts [NUM_PHASES];
      sb = new();
      rom_counts = '{8'd2, 8'd128, 8'd1, 8'd0, 8'd255, 8'd64, 8'd33, 8'd0, 8'd127, 8'd96};
      ram_counts = '{3'd1, 3'd4,   3'd1, 3'd0, 3'd7,   3'd3,  3'd5,  3'd0, 3'd2,   3'd6};
      rom_counts[7] = 8'($urandom_range(1, 128));
      ram_counts[7] = 3'($urandom_range(1, 4));
      quiet               = 1'b0;
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_addr            = '0;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.action      = ACT_READ;
      req_bus.bus_address = '0;
      req_bus.write_data  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // phase 0 runs on the reset bank counts
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p > 0) begin
            while (sb.pending() != 0) @(posedge clock);
            write_counts(rom_counts[p], ram_counts[p]);
         end
         if (p == NUM_PHASES - 1) quiet = 1'b1;
         if (p == 1) send_directed();
         send_random(p == 0 ? 150 : 185);
         req_bus.valid <= 1'b0;
      end

      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
